// ----- rtl/core/depq_pkg.sv -----
// Shared types and constants for the double-ended priority queue.
// No dependencies.
package depq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_POP_MAX = 2'd1;
  localparam logic [1:0] CMD_POP_MIN = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REMOVED  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

endpackage

// ----- rtl/core/depq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module depq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/double_ended_priority_queue_core.sv -----
// Top level of the double-ended priority queue: sequencer around one entry RAM.
// Depends on depq_pkg and depq_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  command  | valid_i / stall_o  | cmd_i, key_i, value_i
//  result   | valid_o / stall_i  | status_o, removed_value_o
//
// Entries sit in a circular buffer in ascending key order; head pointer moves on pop-min.
// A pop reads the entry from idle and removes it in the pop state; an empty pop answers from
// idle. An insert runs a binary search (each probe a read, then a compare), a decision, a shift
// of each entry above the slot through the single RAM read port, and a write; a duplicate or a
// full store ends right after the decision. Reset clears state, count, head and result valid
// only; no clearing pass. A command is taken only when idle and the result register is empty.
module double_ended_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  cmd_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] removed_value_o
);

  localparam int unsigned IW = depq_pkg::IDX_W;
  localparam int unsigned CW = depq_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_CMP, S_SHIFT, S_INS_WR, S_POP
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, j_q, j_d, mid;
  logic          dup_q, dup_d;
  logic [1:0]    cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d, val_q, val_d;
  logic          out_vld_q, out_vld_d;
  logic [2:0]    out_st_q, out_st_d;
  logic signed [31:0] out_val_q, out_val_d;
  logic          accept;
  logic [CW:0]   lohi_sum;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  depq_pkg::entry_t wr_data, rd_data;

  // map a logical position onto the circular buffer
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, h} + {1'b0, l};
    if (s >= (CW+1)'(depq_pkg::CAPACITY)) begin
      s = s - (CW+1)'(depq_pkg::CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  depq_ram #(
    .DEPTH (depq_pkg::CAPACITY),
    .WIDTH ($bits(depq_pkg::entry_t))
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign stall_o         = (state_q != S_IDLE) || out_vld_q;
  assign accept          = valid_i && !stall_o;
  assign valid_o         = out_vld_q;
  assign status_o        = out_st_q;
  assign removed_value_o = out_val_q;
  assign lohi_sum        = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid             = lohi_sum[CW:1];

  // sequence search, shift and pop over the RAM
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    j_d       = j_q;
    dup_d     = dup_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    val_d     = val_q;
    out_vld_d = out_vld_q && stall_i;
    out_st_d  = out_st_q;
    out_val_d = out_val_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '{key: key_q, value: val_q};
    rd_en     = 1'b0;
    rd_addr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          key_d = key_i;
          val_d = value_i;
          if (cmd_i == depq_pkg::CMD_INSERT) begin
            lo_d    = '0;
            hi_d    = cnt_q;
            dup_d   = 1'b0;
            state_d = S_SRCH;
          end else if (cnt_q == '0) begin
            out_vld_d = 1'b1;
            out_st_d  = depq_pkg::ST_EMPTY;
            out_val_d = '0;
          end else begin
            rd_en   = 1'b1;
            rd_addr = (cmd_i == depq_pkg::CMD_POP_MAX) ? phys(head_q, cnt_q - 1'b1) : head_q;
            state_d = S_POP;
          end
        end
      end
      S_SRCH: begin
        if (lo_q == hi_q) begin
          if (dup_q) begin
            out_vld_d = 1'b1;
            out_st_d  = depq_pkg::ST_DUP;
            out_val_d = '0;
            state_d   = S_IDLE;
          end else if (cnt_q == CW'(depq_pkg::CAPACITY)) begin
            out_vld_d = 1'b1;
            out_st_d  = depq_pkg::ST_FULL;
            out_val_d = '0;
            state_d   = S_IDLE;
          end else if (lo_q == cnt_q) begin
            state_d = S_INS_WR;
          end else begin
            // start moving the tail up by one, topmost entry first
            j_d     = cnt_q - 1'b1;
            rd_en   = 1'b1;
            rd_addr = phys(head_q, cnt_q - 1'b1);
            state_d = S_SHIFT;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head_q, mid);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data.key < key_q) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
          if (rd_data.key == key_q) begin
            dup_d = 1'b1;
          end
        end
        state_d = S_SRCH;
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, j_q + 1'b1);
        wr_data = rd_data;
        if (j_q == lo_q) begin
          state_d = S_INS_WR;
        end else begin
          j_d     = j_q - 1'b1;
          rd_en   = 1'b1;
          rd_addr = phys(head_q, j_q - 1'b1);
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_q, lo_q);
        cnt_d     = cnt_q + 1'b1;
        out_vld_d = 1'b1;
        out_st_d  = depq_pkg::ST_INSERTED;
        out_val_d = '0;
        state_d   = S_IDLE;
      end
      S_POP: begin
        cnt_d = cnt_q - 1'b1;
        if (cmd_q != depq_pkg::CMD_POP_MAX) begin
          head_d = phys(head_q, CW'(1));
        end
        out_vld_d = 1'b1;
        out_st_d  = depq_pkg::ST_REMOVED;
        out_val_d = rd_data.value;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold control state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload and search registers
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    j_q       <= j_d;
    dup_q     <= dup_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
  end

endmodule

// ----- rtl/core/depq_checker.sv -----
// Port-level checks for the double-ended priority queue and their bind.
// Depends on depq_pkg and double_ended_priority_queue_core.
module depq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [2:0]  status_o,
  input logic signed [31:0] removed_value_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(status_o) && $stable(removed_value_o))
    else $error("result changed while stalled");

  // status is a known code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o <= depq_pkg::ST_DUP)
    else $error("bad status code");

  // only a removal carries a value
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != depq_pkg::ST_REMOVED |-> removed_value_o == '0)
    else $error("value on non-removal");

  // a transfer in makes the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("accepted a second command at once");

endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (valid_i),
  .stall_o         (stall_o),
  .valid_o         (valid_o),
  .stall_i         (stall_i),
  .status_o        (status_o),
  .removed_value_o (removed_value_o)
);

// ----- tb/double_ended_priority_queue_core_tb.sv -----
// Testbench for double_ended_priority_queue_core: random and directed commands,
// a sorted-queue scoreboard and randomized flow control. Depends on depq_pkg and the core.
module double_ended_priority_queue_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 450;

  // Sorted shadow of the queue contents plus the results still owed by the block
  class depq_scoreboard;
    depq_pkg::entry_t sorted_entries[$];
    logic [2:0]  want_status[$];
    logic [31:0] want_value[$];
    int unsigned errors;
    int unsigned checked;

    function int unsigned occupancy();
      return sorted_entries.size();
    endfunction

    function int unsigned pending();
      return want_status.size();
    endfunction

    // Update the shadow for an accepted command and queue its outcome
    function void note_command(logic [1:0] cmd, logic signed [31:0] key,
                               logic signed [31:0] value);
      int unsigned pos;
      depq_pkg::entry_t ent;
      logic [2:0] st;
      logic [31:0] got;
      pos = 0;
      got = '0;
      if (cmd == depq_pkg::CMD_INSERT) begin
        while (pos < sorted_entries.size() && sorted_entries[pos].key < key) pos++;
        if (pos < sorted_entries.size() && sorted_entries[pos].key == key) begin
          st = depq_pkg::ST_DUP;
        end else if (sorted_entries.size() >= depq_pkg::CAPACITY) begin
          st = depq_pkg::ST_FULL;
        end else begin
          ent.key = key;
          ent.value = value;
          sorted_entries.insert(pos, ent);
          st = depq_pkg::ST_INSERTED;
        end
      end else if (sorted_entries.size() == 0) begin
        st = depq_pkg::ST_EMPTY;
      end else if (cmd[1] == 1'b0) begin
        // pop greatest key
        ent = sorted_entries.pop_back();
        got = ent.value;
        st = depq_pkg::ST_REMOVED;
      end else begin
        // pop smallest key; the undefined code falls here as well
        ent = sorted_entries.pop_front();
        got = ent.value;
        st = depq_pkg::ST_REMOVED;
      end
      want_status.push_back(st);
      want_value.push_back(got);
    endfunction

    // Compare one result transfer against the oldest outcome
    function void check_result(logic [2:0] status, logic [31:0] value);
      logic [2:0] st;
      logic [31:0] v;
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, status, value);
        errors++;
        return;
      end
      st = want_status.pop_front();
      v = want_value.pop_front();
      checked++;
      if (status !== st) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, st, status);
        errors++;
      end
      if (value !== v) begin
        $display("%0t: removed_value mismatch expected=%h actual=%h", $time, v, value);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [1:0]  cmd_i;
  logic signed [31:0] key_i;
  logic signed [31:0] value_i;
  logic        valid_o;
  logic        stall_i;
  logic [2:0]  status_o;
  logic signed [31:0] removed_value_o;

  depq_scoreboard sb;
  int unsigned cycles;
  int unsigned hold_request;
  bit          quiet_sink;

  double_ended_priority_queue_core u_top (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .cmd_i,
    .key_i,
    .value_i,
    .valid_o,
    .stall_i,
    .status_o,
    .removed_value_o
  );

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // Result side: check transfers, pick the next stall, watch the cycle budget
  initial begin
    int unsigned hold_cnt;
    int unsigned r;
    hold_cnt = 0;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
      if (rst_ni && valid_o && !stall_i) sb.check_result(status_o, removed_value_o);
      if (hold_request != 0) begin
        hold_cnt = hold_request;
        hold_request = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        stall_i <= 1'b1;
      end else if (quiet_sink) begin
        stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) stall_i <= 1'b0;
        else if (r < 97) stall_i <= 1'b1;
        else hold_cnt = $urandom_range(10, 40);
      end
    end
  end

  // Offer one command and hold it until the block takes it
  task automatic send(logic [1:0] cmd, logic signed [31:0] key, logic signed [31:0] value);
    valid_i <= 1'b1;
    cmd_i   <= cmd;
    key_i   <= key;
    value_i <= value;
    do @(posedge clk_i); while (stall_o);
    sb.note_command(cmd, key, value);
  endtask

  // Drop valid for a random gap, mostly short, now and then long
  task automatic idle_gap(bit no_gaps);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!no_gaps) begin
      if (r >= 60 && r < 92) n = $urandom_range(1, 3);
      else if (r >= 92) n = $urandom_range(10, 40);
    end
    if (n != 0) begin
      valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_gap(logic [1:0] cmd, logic signed [31:0] key,
                          logic signed [31:0] value, bit no_gaps);
    send(cmd, key, value);
    idle_gap(no_gaps);
  endtask

  task automatic drain_sender();
    valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r;
    logic [1:0] c;
    logic signed [31:0] k;
    bit no_gaps;
    sb = new();
    cycles = 0;
    hold_request = 0;
    quiet_sink = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    cmd_i = depq_pkg::CMD_INSERT;
    key_i = '0;
    value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops, key extremes, duplicates, every command code
    send_gap(depq_pkg::CMD_POP_MAX, 32'h7fffffff, 32'hffffffff, 1'b0);
    send_gap(depq_pkg::CMD_POP_MIN, 32'h80000000, 32'h7fffffff, 1'b0);
    send_gap(2'd3, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h80000000, 32'h80000000, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h0, 32'hffffffff, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'hffffffff, 32'h00000001, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h7fffffff, 32'h12345678, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h80000000, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h1, 32'h55555555, 1'b0);
    send_gap(depq_pkg::CMD_POP_MAX, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_POP_MIN, 32'hffffffff, 32'hffffffff, 1'b0);
    send_gap(2'd3, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_POP_MAX, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_POP_MAX, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_POP_MIN, 32'h0, 32'h0, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h2aaaaaaa, 32'haaaaaaaa, 1'b0);
    send_gap(2'd3, 32'h0, 32'h0, 1'b0);

    // Random: half of the keys from a narrow window so duplicates happen often
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps = (i % 100) < 25;
      quiet_sink = (i % 150) >= 120;
      if (i == 200) hold_request = 400;
      if (i == 400) drain_sender();
      r = $urandom_range(0, 99);
      if (sb.occupancy() > 120) c = (r < 30) ? depq_pkg::CMD_INSERT : depq_pkg::CMD_POP_MAX;
      else c = (r < 55) ? depq_pkg::CMD_INSERT : depq_pkg::CMD_POP_MAX;
      if (c == depq_pkg::CMD_POP_MAX) begin
        r = $urandom_range(0, 9);
        if (r < 5) c = depq_pkg::CMD_POP_MIN;
        else if (r == 9) c = 2'd3;
      end
      k = ($urandom_range(0, 1) != 0) ? $signed($urandom_range(0, 48)) - 24
                                      : $signed($urandom);
      send_gap(c, k, $urandom, no_gaps);
    end

    // Empty the queue, then place entries at both key extremes
    while (sb.occupancy() != 0) begin
      send_gap(depq_pkg::CMD_POP_MIN, $urandom, $urandom, 1'b0);
    end
    send_gap(depq_pkg::CMD_INSERT, 32'h7fffffff, $urandom, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h80000000, 32'hdeadbeef, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h80000000, $urandom, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h7fffffff, $urandom, 1'b0);
    send_gap(depq_pkg::CMD_INSERT, 32'h0, $urandom, 1'b0);
    // Empty it again from both ends
    while (sb.occupancy() != 0) begin
      r = $urandom_range(0, 2);
      c = (r == 0) ? depq_pkg::CMD_POP_MAX : (r == 1) ? depq_pkg::CMD_POP_MIN : 2'd3;
      send_gap(c, $urandom, $urandom, 1'b0);
    end
    send_gap(depq_pkg::CMD_POP_MAX, 32'h0, 32'h0, 1'b0);

    // Let the last results come out, then settle
    drain_sender();
    repeat (50) @(posedge clk_i);
    $display("Covered empty pops, key extremes, duplicates and random mixes under stalls");
    $display("Checked %0d results in %0d cycles", sb.checked, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
